FILE: hdl/led_matrix_scroll_scanner_macros.svh
// Assertion macros for the LED matrix scroll scanner.
`ifndef LED_MATRIX_SCROLL_SCANNER_MACROS_SVH
`define LED_MATRIX_SCROLL_SCANNER_MACROS_SVH

`ifndef SYNTHESIS
`define LMSS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lmss assertion failed");
`define LMSS_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lmss assertion failed");
`else
`define LMSS_ASSERT_IMP(label, clk, rst, ante, cons)
`define LMSS_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: hdl/lmss_pkg.sv
`default_nettype none

package lmss_pkg;

  localparam int SLOT_COUNT_DEF = 16;
  localparam int ROWS           = 8;

  localparam int CMD_W     = 2;
  localparam int SLOT_W    = 4;
  localparam int ROW_W     = 3;
  localparam int BYTE_W    = 8;
  localparam int PERIOD_W  = 16;
  localparam int GLYPHS_W  = 4;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(200);
  localparam logic [GLYPHS_W-1:0] GLYPHS_RESET = GLYPHS_W'(1);

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK       = 2'd0,
    CMD_LOAD_SLOT  = 2'd1,
    CMD_LOAD_FRAME = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PERIOD    = 2'd0,
    CFG_DIRECTION = 2'd1,
    CFG_GLYPHS    = 2'd2
  } cfg_idx_t;

endpackage

`default_nettype wire

FILE: hdl/lmss_req_if.sv
`default_nettype none

interface lmss_req_if;
  logic                           valid;
  logic                           ready;
  logic [lmss_pkg::CMD_W-1:0]     cmd;
  logic [lmss_pkg::SLOT_W-1:0]    slot;
  logic [lmss_pkg::ROW_W-1:0]     row;
  logic [lmss_pkg::BYTE_W-1:0]    pattern;

  modport source (output valid, cmd, slot, row, pattern, input ready);
  modport sink (input valid, cmd, slot, row, pattern, output ready);
endinterface

`default_nettype wire

FILE: hdl/lmss_rsp_if.sv
`default_nettype none

interface lmss_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [lmss_pkg::BYTE_W-1:0]    column_drive;
  logic [lmss_pkg::BYTE_W-1:0]    row_drive;
  logic [lmss_pkg::ROW_W-1:0]     scan_column;
  logic                           scrolled;

  modport source (output valid, column_drive, row_drive, scan_column, scrolled, input ready);
  modport sink (input valid, column_drive, row_drive, scan_column, scrolled, output ready);
endinterface

`default_nettype wire

FILE: hdl/lmss_ram.sv
`default_nettype none

module lmss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

FILE: hdl/led_matrix_scroll_scanner.sv
// Loads may follow back to back. A tick with no scroll step passes through the emit
// state, which waits while an earlier result is untaken; then the result and next
// request can be taken. A tick that rebuilds the frame runs the rebuild state first: 16
// single-port glyph RAM reads (current and next slot per row) feed one shifter.
// Synchronous reset clears control state and configuration, then a pass zeroes all
// SLOT_COUNT*8 glyph RAM entries with req.ready low; config writes are taken meanwhile.
`default_nettype none
`include "led_matrix_scroll_scanner_macros.svh"

module led_matrix_scroll_scanner #(
  parameter int SLOT_COUNT = lmss_pkg::SLOT_COUNT_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [lmss_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [lmss_pkg::CFG_DATA_W-1:0]   cfg_data,
  lmss_req_if.sink                               req,
  lmss_rsp_if.source                             rsp
);

  localparam int DEPTH  = SLOT_COUNT * lmss_pkg::ROWS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [4:0] STEP_LAST = 5'(2 * lmss_pkg::ROWS);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REBUILD,
    ST_EMIT
  } state_t;

  function automatic logic slot_ok(input logic [lmss_pkg::SLOT_W-1:0] s);
    return int'(s) < SLOT_COUNT;
  endfunction

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [lmss_pkg::SLOT_W-1:0] s,
                                                  input logic [lmss_pkg::ROW_W-1:0] r);
    return ADDR_W'({28'(s), r});
  endfunction

  state_t                          state;
  logic [ADDR_W-1:0]               clr_addr;
  logic [4:0]                      step;
  logic [lmss_pkg::ROW_W-1:0]      rd_row;
  logic                            rd_nxt;
  logic                            rd_ok;
  logic [7:0]                      a_byte;
  logic [7:0]                      frame [lmss_pkg::ROWS];
  logic [2:0]                      bit_offset;
  logic [3:0]                      slot_position;
  logic [15:0]                     elapsed;
  logic [2:0]                      column_counter;
  logic [2:0]                      tick_col;
  logic                            tick_did;
  logic                            rsp_valid;
  logic [7:0]                      column_drive;
  logic [7:0]                      row_drive;
  logic [2:0]                      scan_column;
  logic                            scrolled;

  logic [15:0]                     scroll_period;
  logic                            direction;
  logic [3:0]                      glyph_count;

  logic                            ram_we;
  logic [ADDR_W-1:0]               ram_addr;
  logic [7:0]                      ram_wdata;
  logic [7:0]                      ram_rdata;
  logic [3:0]                      nxt_slot;
  logic [3:0]                      rd_slot;
  logic [7:0]                      b_byte;
  logic [15:0]                     shr;
  logic [15:0]                     shl;
  logic [7:0]                      shifted;
  logic                            do_scroll;

  lmss_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_glyph_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign nxt_slot  = (slot_position >= glyph_count) ? 4'd0 : slot_position + 4'd1;
  assign rd_slot   = step[0] ? nxt_slot : slot_position;
  assign b_byte    = ram_rdata & {8{rd_ok}};
  assign shr       = {b_byte, a_byte} >> bit_offset;
  assign shl       = {a_byte, b_byte} << bit_offset;
  assign shifted   = direction ? shl[15:8] : shr[7:0];
  assign do_scroll = (column_counter == 3'd0) && (elapsed >= scroll_period);

  assign req.ready         = (state == ST_IDLE);
  assign rsp.valid         = rsp_valid;
  assign rsp.column_drive  = column_drive;
  assign rsp.row_drive     = row_drive;
  assign rsp.scan_column   = scan_column;
  assign rsp.scrolled      = scrolled;

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = '0;
    ram_wdata = '0;
    unique case (state)
      ST_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_addr;
      end
      ST_IDLE: begin
        if (req.valid && req.cmd == lmss_pkg::CMD_LOAD_SLOT && req.slot != '0
            && slot_ok(req.slot)) begin
          ram_we    = 1'b1;
          ram_addr  = slot_addr(req.slot, req.row);
          ram_wdata = req.pattern;
        end
      end
      ST_REBUILD: begin
        ram_addr = slot_addr(rd_slot, step[3:1]);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scroll_period <= lmss_pkg::PERIOD_RESET;
      direction     <= 1'b0;
      glyph_count   <= lmss_pkg::GLYPHS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        lmss_pkg::CFG_PERIOD:    scroll_period <= cfg_data;
        lmss_pkg::CFG_DIRECTION: direction     <= cfg_data[0];
        lmss_pkg::CFG_GLYPHS:    glyph_count   <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      clr_addr       <= '0;
      step           <= '0;
      rd_row         <= '0;
      rd_nxt         <= 1'b0;
      rd_ok          <= 1'b0;
      a_byte         <= '0;
      frame          <= '{default: '0};
      bit_offset     <= '0;
      slot_position  <= '0;
      elapsed        <= '0;
      column_counter <= '0;
      tick_col       <= '0;
      tick_did       <= 1'b0;
      rsp_valid      <= 1'b0;
    end else begin
      if (rsp_valid && rsp.ready && state != ST_EMIT) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == ADDR_W'(DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (req.valid) begin
            unique case (req.cmd)
              lmss_pkg::CMD_TICK: begin
                tick_col       <= column_counter;
                tick_did       <= do_scroll;
                column_counter <= column_counter + 3'd1;
                step           <= '0;
                if (do_scroll) begin
                  elapsed <= 16'd1;
                  state   <= ST_REBUILD;
                end else begin
                  if (elapsed != 16'hFFFF) begin
                    elapsed <= elapsed + 16'd1;
                  end
                  state <= ST_EMIT;
                end
              end
              lmss_pkg::CMD_LOAD_FRAME: begin
                frame[req.row] <= req.pattern;
              end
              default: ;
            endcase
          end
        end
        ST_REBUILD: begin
          rd_row <= step[3:1];
          rd_nxt <= step[0];
          rd_ok  <= slot_ok(rd_slot);
          step   <= step + 5'd1;
          if (step != 5'd0) begin
            if (rd_nxt) begin
              frame[rd_row] <= shifted;
            end else begin
              a_byte <= b_byte;
            end
          end
          if (step == STEP_LAST) begin
            bit_offset <= bit_offset + 3'd1;
            if (bit_offset == 3'd7) begin
              slot_position <= nxt_slot;
            end
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid    <= 1'b1;
            column_drive <= ~(8'd1 << tick_col);
            row_drive    <= frame[tick_col];
            scan_column  <= tick_col;
            scrolled     <= tick_did;
            state        <= ST_IDLE;
          end
        end
        default: ;
      endcase
    end
  end

  `LMSS_ASSERT_IMP(a_col_onehot, clk, rst, rsp.valid, rsp.column_drive == ~(8'd1 << rsp.scan_column))
  `LMSS_ASSERT_IMP(a_scroll_col0, clk, rst, rsp.valid && rsp.scrolled, rsp.scan_column == 3'd0)
  `LMSS_ASSERT_NXT(a_frame_load, clk, rst, req.valid && req.ready && req.cmd == lmss_pkg::CMD_LOAD_FRAME, frame[$past(req.row)] == $past(req.pattern))

endmodule

`default_nettype wire
